FILE: rtl/core/assert_macros.svh
// Assertion macros for the core RTL. Each use names a label, a property and a message.
// The properties are clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ROTL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define ROTL_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define ROTL_ASSERT(label, prop, msg)

`define ROTL_ASSERT_NEVER(label, expr, msg)

`endif

`endif

FILE: rtl/core/rotl_pkg.sv
`default_nettype none

package rotl_pkg;

	localparam int TABLE_SLOTS_DEF = 64;
	localparam int LOG_DEPTH_DEF   = 16;

	localparam int TYPE_W = 8;
	localparam int RES_W  = 16;
	localparam int OWN_W  = 16;
	localparam int IDX_W  = 4;
	localparam int CNT_W  = 5;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_READ    = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [TYPE_W-1:0] req_type;
		logic [RES_W-1:0]  resource;
		logic [OWN_W-1:0]  requester;
		logic [IDX_W-1:0]  log_index;
	} rotl_in_t;

	typedef struct packed {
		logic              granted;
		logic              log_valid;
		logic [CNT_W-1:0]  log_count;
		logic [TYPE_W-1:0] log_type;
		logic [RES_W-1:0]  log_resource;
		logic [OWN_W-1:0]  log_owner;
		logic              log_granted;
	} rotl_out_t;

	typedef struct packed {
		logic [TYPE_W-1:0] rec_type;
		logic [RES_W-1:0]  rec_resource;
		logic [OWN_W-1:0]  rec_owner;
		logic              rec_granted;
	} rotl_entry_t;

	// Running flags passed from cell to cell, lowest slot first
	typedef struct packed {
		logic hit;
		logic free;
		logic ok;
	} rotl_chain_t;

endpackage

`default_nettype wire

FILE: rtl/core/resource_owner_table_with_log.sv
`default_nettype none

// Resource ownership table with a request log. When an item is accepted, each slot
// cell compares its class, id and owner against the item and the log memory is read;
// in the update state the lowest matching held slot, or failing that the lowest free
// slot, is resolved along the row of cells; once the result register is free it is
// loaded and, for a request, the log and a fresh slot on a miss are written. The
// result register lets the next item be accepted while a result still waits; the block
// holds in its update state only while an earlier result is not taken. Log reads count
// from the oldest entry; reads past the fill level return zeros with log_valid low.
module resource_owner_table_with_log #(
	parameter int TABLE_SLOTS = rotl_pkg::TABLE_SLOTS_DEF,
	parameter int LOG_DEPTH   = rotl_pkg::LOG_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire rotl_pkg::rotl_in_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output rotl_pkg::rotl_out_t     rsp
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_UPDATE = 2'b10
	} rotl_state_t;

	rotl_state_t           st_q;
	rotl_pkg::rotl_in_t    req_q;
	rotl_pkg::rotl_out_t   rsp_q;
	logic                  rsp_valid_q;
	logic                  accept;
	logic                  can_load;
	logic                  commit;
	logic                  granted;
	logic                  no_hit;
	rotl_pkg::rotl_chain_t chain [TABLE_SLOTS+1];
	logic [TABLE_SLOTS-1:0] slot_wr;
	rotl_pkg::rotl_entry_t log_wr;
	rotl_pkg::rotl_entry_t log_rd;
	logic                  log_hit;
	logic [rotl_pkg::CNT_W-1:0] log_count;

	assign req_ready = (st_q == ST_IDLE);
	assign accept    = req_valid & req_ready;
	assign can_load  = ~rsp_valid_q | rsp_ready;
	assign commit    = (st_q == ST_UPDATE) & can_load & (req_q.opcode == rotl_pkg::OP_REQUEST);

	assign chain[0] = '0;
	assign no_hit   = ~chain[TABLE_SLOTS].hit;

	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		rotl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.capture  (accept),
			.cmp_item (req),
			.commit   (commit),
			.wr_item  (req_q),
			.no_hit   (no_hit),
			.chain_in (chain[i]),
			.chain_out(chain[i+1]),
			.wr       (slot_wr[i])
		);
	end

	assign granted = chain[TABLE_SLOTS].hit ? chain[TABLE_SLOTS].ok
		: chain[TABLE_SLOTS].free;

	assign log_wr.rec_type     = req_q.req_type;
	assign log_wr.rec_resource = req_q.resource;
	assign log_wr.rec_owner    = req_q.requester;
	assign log_wr.rec_granted  = granted;

	rotl_log #(
		.LOG_DEPTH(LOG_DEPTH)
	) u_log (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_req  (req.opcode == rotl_pkg::OP_READ),
		.rd_idx  (req.log_index),
		.wr_en   (commit),
		.wr_entry(log_wr),
		.rd_entry(log_rd),
		.rd_hit  (log_hit),
		.count   (log_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (can_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if ((st_q == ST_UPDATE) && can_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if ((st_q == ST_UPDATE) && can_load) begin
			rsp_q.granted      <= (req_q.opcode == rotl_pkg::OP_REQUEST) & granted;
			rsp_q.log_valid    <= log_hit;
			rsp_q.log_count    <= log_count;
			rsp_q.log_type     <= log_hit ? log_rd.rec_type : '0;
			rsp_q.log_resource <= log_hit ? log_rd.rec_resource : '0;
			rsp_q.log_owner    <= log_hit ? log_rd.rec_owner : '0;
			rsp_q.log_granted  <= log_hit & log_rd.rec_granted;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "assert_macros.svh"

	`ROTL_ASSERT(a_one_slot_written, $onehot0(slot_wr), "more than one slot written")
	`ROTL_ASSERT(a_fresh_slot_on_miss, (commit && no_hit && chain[TABLE_SLOTS].free) |-> ($countones(slot_wr) == 1), "free slot not taken on miss")
	`ROTL_ASSERT(a_accept_to_update, accept |=> (st_q == ST_UPDATE && !req_ready), "accept did not move to update")
	`ROTL_ASSERT_NEVER(a_no_stall_when_empty, (st_q == ST_UPDATE) && !rsp_valid_q && !can_load, "update stalled with empty result register")

endmodule

`default_nettype wire

FILE: rtl/core/rotl_cell.sv
`default_nettype none

module rotl_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  capture,
	input  wire rotl_pkg::rotl_in_t    cmp_item,
	input  wire logic                  commit,
	input  wire rotl_pkg::rotl_in_t    wr_item,
	input  wire logic                  no_hit,
	input  wire rotl_pkg::rotl_chain_t chain_in,
	output rotl_pkg::rotl_chain_t      chain_out,
	output logic                       wr
);

	logic [rotl_pkg::TYPE_W-1:0] type_q;
	logic [rotl_pkg::RES_W-1:0]  res_q;
	logic [rotl_pkg::OWN_W-1:0]  owner_q;
	logic                        hit_q;
	logic                        free_q;
	logic                        own_q;
	logic                        sel_hit;
	logic                        sel_free;

	// Compare against the incoming item while it is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			own_q  <= 1'b0;
		end else if (capture) begin
			hit_q  <= (owner_q != '0) && (type_q == cmp_item.req_type)
				&& (res_q == cmp_item.resource);
			free_q <= (owner_q == '0);
			own_q  <= (owner_q == cmp_item.requester);
		end
	end

	assign sel_hit  = hit_q & ~chain_in.hit;
	assign sel_free = free_q & ~chain_in.free & no_hit;

	assign chain_out.hit  = chain_in.hit | hit_q;
	assign chain_out.free = chain_in.free | free_q;
	assign chain_out.ok   = chain_in.ok | (sel_hit & own_q);

	// A hit that is granted keeps its owner, so only a fresh slot is written
	assign wr = commit & sel_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q  <= '0;
			res_q   <= '0;
			owner_q <= '0;
		end else if (wr) begin
			type_q  <= wr_item.req_type;
			res_q   <= wr_item.resource;
			owner_q <= wr_item.requester;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rotl_log.sv
`default_nettype none

module rotl_log #(
	parameter int LOG_DEPTH = rotl_pkg::LOG_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic                          rd_req,
	input  wire logic [rotl_pkg::IDX_W-1:0]    rd_idx,
	input  wire logic                          wr_en,
	input  wire rotl_pkg::rotl_entry_t         wr_entry,
	output rotl_pkg::rotl_entry_t              rd_entry,
	output logic                               rd_hit,
	output logic [rotl_pkg::CNT_W-1:0]         count
);

	localparam int AW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CW   = $clog2(LOG_DEPTH + 1);
	localparam int SW   = ((AW > rotl_pkg::IDX_W) ? AW : rotl_pkg::IDX_W) + 1;
	localparam int CMPW = (CW > rotl_pkg::IDX_W) ? CW : rotl_pkg::IDX_W;

	rotl_pkg::rotl_entry_t mem [LOG_DEPTH];

	logic [AW-1:0] head_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] fill_nx;
	logic          full;
	logic [AW-1:0] oldest;
	logic [SW-1:0] pos_sum;
	logic [SW-1:0] pos_wrap;
	logic          in_range;

	assign full     = (fill_q == CW'(LOG_DEPTH));
	assign oldest   = full ? head_q : '0;
	assign pos_sum  = SW'(oldest) + SW'(rd_idx);
	assign pos_wrap = (pos_sum >= SW'(LOG_DEPTH)) ? (pos_sum - SW'(LOG_DEPTH)) : pos_sum;
	assign in_range = (CMPW'(rd_idx) < CMPW'(fill_q));

	assign fill_nx = (wr_en && !full) ? (fill_q + 1'b1) : fill_q;
	assign count   = rotl_pkg::CNT_W'(fill_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			rd_hit <= 1'b0;
		end else begin
			if (wr_en) begin
				head_q <= (head_q == AW'(LOG_DEPTH - 1)) ? '0 : (head_q + 1'b1);
				fill_q <= fill_nx;
			end
			if (rd_en) begin
				rd_hit <= rd_req & in_range;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[head_q] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry <= mem[pos_wrap[AW-1:0]];
		end
	end

endmodule

`default_nettype wire
